FILE: rtl/nlej_pkg.sv
`default_nettype none

package nlej_pkg;

   // Default number of rows the build table holds.
   localparam int DEF_TABLE_DEPTH = 16;

   // Request codes carried in the req_type field.
   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_PROBE = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   // Register indexes on the configuration port.
   typedef enum logic {
      CSR_PROBE_KEY_COL = 1'b0,
      CSR_BUILD_KEY_COL = 1'b1
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SCAN  = 2'd1,
      ST_FLUSH = 2'd2
   } state_type;

   // One incoming request.
   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] col_zero;
      logic signed [31:0] col_one;
   } req_payload_type;

   // One join result.
   typedef struct packed {
      logic signed [31:0] probe_other;
      logic signed [31:0] join_key;
      logic signed [31:0] build_other;
      logic               last_match;
   } rsp_payload_type;

   // Control handed from the sequencer to each row cell.
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/nlej_cell.sv
`default_nettype none

module nlej_cell
   import nlej_pkg::*;
(
   input  wire logic               clock,
   input  wire cell_ctl_type       ctl,
   input  wire logic signed [31:0] load_col_zero,
   input  wire logic signed [31:0] load_col_one,
   input  wire logic signed [31:0] next_col_zero,
   input  wire logic signed [31:0] next_col_one,
   output logic signed [31:0]      col_zero,
   output logic signed [31:0]      col_one
);

   logic signed [31:0] col_zero_ff;
   logic signed [31:0] col_one_ff;

   // A cell takes a new row on load, or its neighbor's row when the ring rotates.
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         col_zero_ff <= load_col_zero;
         col_one_ff  <= load_col_one;
      end else if (ctl.shift) begin
         col_zero_ff <= next_col_zero;
         col_one_ff  <= next_col_one;
      end
   end

   assign col_zero = col_zero_ff;
   assign col_one  = col_one_ff;

endmodule

`default_nettype wire

FILE: rtl/nested_loop_equi_join.sv
// Nested-loop equi-join with an internal build table of TABLE_DEPTH rows.
// Requests arrive on req_valid / req_stall / req_data. A load appends one row
// (dropped once the table is full), a clear empties the table, and a probe
// compares its key column against every stored row in index order. Results
// leave on rsp_valid / rsp_stall / rsp_data, one per matching row, with
// last_match set on the final one; a probe with no match gives no result.
// Load, clear and the unused code leave the block idle. The rows sit in a ring
// of cells that rotates one place per cycle, unless a stalled result halts it,
// past a single comparator, so a probe occupies the block for a scan of all
// TABLE_DEPTH cells and a flush, longer while the receiver stalls; req_stall
// is high for that whole time. The first result is registered once the
// second matching row is at the head of the ring and the output register is
// free; with a single match, in the flush. A stalled result holds in the
// output register and halts the ring only when a further result is ready.
// The csr port selects the key column of the probe and of the stored rows
// and must be written only while the block is idle. A synchronous reset
// empties the table, resets both key selects to column zero and drops any
// result not yet taken; stored row contents are not cleared.
`default_nettype none

module nested_loop_equi_join
   import nlej_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   output logic           req_stall,
   input  wire req_payload_type req_data,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output rsp_payload_type rsp_data,
   input  wire logic      csr_write,
   input  wire logic      csr_index,
   input  wire logic      csr_data
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [IW-1:0] SCAN_LAST = IW'(TABLE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

   state_type state_ff, state_in;
   logic [IW-1:0] scan_ff;
   logic [CW-1:0] row_count_ff;
   logic probe_key_col_ff, build_key_col_ff;
   logic signed [31:0] pkey_ff, pother_ff;
   logic pend_valid_ff;
   logic signed [31:0] pend_other_ff;
   logic rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   logic signed [31:0] cell_zero [TABLE_DEPTH];
   logic signed [31:0] cell_one [TABLE_DEPTH];
   cell_ctl_type cell_ctl [TABLE_DEPTH];

   logic signed [31:0] head_key, head_other;
   logic hit, can_move, idle_fire;
   logic adv, emit, emit_last, pend_set, pend_clr, done;
   logic start_probe, do_load, do_clear;

   // The ring of row cells; each passes its row to the one below on rotation.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      localparam int NXT = (i + 1) % TABLE_DEPTH;
      assign cell_ctl[i].shift = adv;
      assign cell_ctl[i].load  = do_load && (row_count_ff < FULL_COUNT) &&
                                 (row_count_ff == CW'(i));
      nlej_cell u_cell (
         .clock         (clock),
         .ctl           (cell_ctl[i]),
         .load_col_zero (req_data.col_zero),
         .load_col_one  (req_data.col_one),
         .next_col_zero (cell_zero[NXT]),
         .next_col_one  (cell_one[NXT]),
         .col_zero      (cell_zero[i]),
         .col_one       (cell_one[i])
      );
   end

   // The head cell faces the comparator.
   assign head_key   = build_key_col_ff ? cell_one[0] : cell_zero[0];
   assign head_other = build_key_col_ff ? cell_zero[0] : cell_one[0];
   assign hit        = (CW'(scan_ff) < row_count_ff) && (head_key == pkey_ff);
   assign can_move   = !rsp_valid_ff || !rsp_stall;

   // Requests are taken only while idle.
   assign req_stall   = (state_ff != ST_IDLE);
   assign idle_fire   = req_valid && (state_ff == ST_IDLE);
   assign start_probe = idle_fire && (req_data.req_type == REQ_PROBE);
   assign do_load     = idle_fire && (req_data.req_type == REQ_LOAD);
   assign do_clear    = idle_fire && (req_data.req_type == REQ_CLEAR);

   // Sequencer outputs. A hit is held back until the next hit or the end of
   // the scan shows whether it is the last one.
   always_comb begin
      adv       = 1'b0;
      emit      = 1'b0;
      emit_last = 1'b0;
      pend_set  = 1'b0;
      pend_clr  = 1'b0;
      done      = 1'b0;
      case (state_ff)
         ST_SCAN: begin
            if (hit && pend_valid_ff) begin
               if (can_move) begin
                  adv      = 1'b1;
                  emit     = 1'b1;
                  pend_set = 1'b1;
               end
            end else if (hit) begin
               adv      = 1'b1;
               pend_set = 1'b1;
            end else begin
               adv = 1'b1;
            end
         end
         ST_FLUSH: begin
            if (pend_valid_ff) begin
               if (can_move) begin
                  emit      = 1'b1;
                  emit_last = 1'b1;
                  pend_clr  = 1'b1;
                  done      = 1'b1;
               end
            end else begin
               done = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_probe) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (adv && (scan_ff == SCAN_LAST)) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (done) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state: sequencer, scan position, row count, key selects, flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         scan_ff          <= '0;
         row_count_ff     <= '0;
         probe_key_col_ff <= 1'b0;
         build_key_col_ff <= 1'b0;
         pend_valid_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (start_probe) begin
            scan_ff <= '0;
         end else if (adv) begin
            scan_ff <= (scan_ff == SCAN_LAST) ? '0 : scan_ff + 1'b1;
         end
         if (do_clear) begin
            row_count_ff <= '0;
         end else if (do_load && (row_count_ff < FULL_COUNT)) begin
            row_count_ff <= row_count_ff + 1'b1;
         end
         if (csr_write && (csr_index == CSR_PROBE_KEY_COL)) probe_key_col_ff <= csr_data;
         if (csr_write && (csr_index == CSR_BUILD_KEY_COL)) build_key_col_ff <= csr_data;
         if (pend_set) begin
            pend_valid_ff <= 1'b1;
         end else if (pend_clr) begin
            pend_valid_ff <= 1'b0;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: probe key and other column, held hit, output register.
   always_ff @(posedge clock) begin
      if (start_probe) begin
         pkey_ff   <= probe_key_col_ff ? req_data.col_one : req_data.col_zero;
         pother_ff <= probe_key_col_ff ? req_data.col_zero : req_data.col_one;
      end
      if (pend_set) pend_other_ff <= head_other;
      if (emit) begin
         rsp_data_ff.probe_other <= pother_ff;
         rsp_data_ff.join_key    <= pkey_ff;
         rsp_data_ff.build_other <= pend_other_ff;
         rsp_data_ff.last_match  <= emit_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // No held hit may survive into the idle state.
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("held hit left over after probe");

   // The row count never exceeds the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      row_count_ff <= FULL_COUNT)
      else $error("row count beyond table depth");

   // The flush state is entered only from the scan.
   a_flush_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_FLUSH) |-> ($past(state_ff) == ST_SCAN))
      else $error("flush entered without scan");

   // The ring is back in place when the probe ends.
   a_scan_wrapped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> (scan_ff == '0))
      else $error("ring not realigned at end of scan");
`endif

endmodule

`default_nettype wire
